>>> hdl/piep_pkg.sv
// Package for the pickle index entry parser: payload structs, opcodes, codes
// and the command passed from the front classifier to the back executor.
// No dependencies; every module of the block imports it.
package piep_pkg;

    // Number of LONG1 value bytes kept; wider values are truncated and flagged.
    localparam int VALUE_BYTES = 8;
    localparam logic [7:0] VALUE_BYTES_W = 8'(VALUE_BYTES);

    // Depth of the command queue between front and back.
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    // Recognized opcodes.
    localparam logic [7:0] OP_BININT        = 8'h4A;
    localparam logic [7:0] OP_LONG1         = 8'h8A;
    localparam logic [7:0] OP_SHORT_UNICODE = 8'h8C;

    // Result kinds.
    localparam logic [1:0] KIND_PATH_START = 2'd0;
    localparam logic [1:0] KIND_PATH_BYTE  = 2'd1;
    localparam logic [1:0] KIND_ENTRY      = 2'd2;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_index;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         path_length;
        logic [7:0]         path_byte;
        logic signed [63:0] entry_offset;
        logic signed [63:0] entry_size;
        logic               has_path;
        logic               value_truncated;
    } result_t;

    // Action the back part takes for one stream byte.
    typedef enum logic [2:0] {
        CMD_SKIP     = 3'd0,
        CMD_VALUE    = 3'd1,
        CMD_STR_LEN  = 3'd2,
        CMD_STR_BYTE = 3'd3
    } cmd_op_t;

    // Classified byte handed from front to back.
    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic [2:0] shift;       // byte lane of a kept value byte
        logic       keep;        // the byte goes into the accumulator
        logic       done;        // this byte completes the value
        logic       sign_ext;    // LONG1 value: sign extend from kept bytes
        logic [3:0] kept;        // number of bytes kept in a LONG1 value
        logic       wide;        // LONG1 value wider than VALUE_BYTES
        logic       last;        // final byte of the index
    } cmd_t;

endpackage

>>> hdl/piep_front.sv
// Front part of the pickle index entry parser: tracks the opcode framing of
// the byte stream and turns every accepted byte into one command.
// Depends on piep_pkg.
module piep_front
    import piep_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output cmd_t     cmd
);

    // Framing phase, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_BININT     = 6'b000010,
        PH_LONG_WIDTH = 6'b000100,
        PH_LONG_BYTES = 6'b001000,
        PH_STR_LEN    = 6'b010000,
        PH_STR_BYTES  = 6'b100000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] pos_inc;
    logic [7:0] b;

    assign b       = item.data_byte;
    assign pos_inc = pos_reg + 8'd1;

    // Classify the byte and advance the framing state.
    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        cmd          = '0;
        cmd.op       = CMD_SKIP;
        cmd.data     = b;
        cmd.last     = item.last_of_index;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (b == OP_BININT)
                begin
                    phase_next = PH_BININT;
                    left_next  = 8'd4;
                    pos_next   = 8'd0;
                end
                else if (b == OP_LONG1)
                begin
                    phase_next = PH_LONG_WIDTH;
                end
                else if (b == OP_SHORT_UNICODE)
                begin
                    phase_next = PH_STR_LEN;
                end
            end
            PH_BININT:
            begin
                cmd.op    = CMD_VALUE;
                cmd.keep  = 1'b1;
                cmd.shift = {1'b0, pos_reg[1:0]};
                cmd.done  = (left_reg == 8'd1);
                pos_next  = pos_inc;
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LONG_WIDTH:
            begin
                pos_next  = 8'd0;
                left_next = b;
                if (b == 8'd0)
                begin
                    // Zero-width LONG1 completes with the value zero.
                    cmd.op       = CMD_VALUE;
                    cmd.done     = 1'b1;
                    cmd.sign_ext = 1'b1;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_LONG_BYTES;
                end
            end
            PH_LONG_BYTES:
            begin
                cmd.op       = CMD_VALUE;
                cmd.keep     = (pos_reg < VALUE_BYTES_W);
                cmd.shift    = pos_reg[2:0];
                cmd.done     = (left_reg == 8'd1);
                cmd.sign_ext = 1'b1;
                cmd.kept     = (pos_inc < VALUE_BYTES_W) ? pos_inc[3:0] : VALUE_BYTES_W[3:0];
                cmd.wide     = (pos_inc > VALUE_BYTES_W);
                pos_next     = pos_inc;
                left_next    = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_STR_LEN:
            begin
                cmd.op     = CMD_STR_LEN;
                left_next  = b;
                phase_next = (b == 8'd0) ? PH_IDLE : PH_STR_BYTES;
            end
            PH_STR_BYTES:
            begin
                cmd.op    = CMD_STR_BYTE;
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        // The final byte of the index drops any partial opcode.
        if (item.last_of_index)
        begin
            phase_next = PH_IDLE;
            left_next  = 8'd0;
            pos_next   = 8'd0;
        end
    end

    // Framing registers advance only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 8'd0;
            pos_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

>>> hdl/piep_cmd_fifo.sv
// Short command queue between the front classifier and the back executor.
// Depends on piep_pkg for the command type and depth.
module piep_cmd_fifo
    import piep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic nonempty
);

    cmd_t                 cmd_mem_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_cmd   = cmd_mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cmd_mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> hdl/piep_back.sv
// Back part of the pickle index entry parser: assembles values, applies the
// key, pairs offsets with sizes and holds the result register.
// Depends on piep_pkg.
module piep_back
    import piep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] key,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output result_t     result,
    output logic        empty,
    input  logic        pop
);

    logic [63:0] acc_reg, acc_next;
    logic [63:0] held_reg, held_next;
    logic        expect_size_reg, expect_size_next;
    logic        path_seen_reg, path_seen_next;
    logic        wide_reg, wide_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        emit;
    logic [63:0] merged;
    logic [63:0] extended;
    logic [63:0] keyed;

    // A command runs when the result register is free or being drained.
    assign cmd_take = cmd_valid && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // Merge the byte into the accumulated value.
    assign merged = acc_reg | (cmd.keep ? (64'(cmd.data) << {cmd.shift, 3'b000}) : 64'd0);

    // Sign extend a LONG1 value from its highest kept byte.
    always_comb
    begin
        extended = merged;
        if (cmd.sign_ext)
        begin
            for (int k = 1; k < 8; k++)
            begin
                if (cmd.kept == 4'(k) && merged[k*8-1])
                begin
                    extended = merged | ({64{1'b1}} << (k * 8));
                end
            end
        end
    end

    assign keyed = extended ^ {32'd0, key};

    // Execute one command.
    always_comb
    begin
        acc_next         = acc_reg;
        held_next        = held_reg;
        expect_size_next = expect_size_reg;
        path_seen_next   = path_seen_reg;
        wide_next        = wide_reg;
        emit             = 1'b0;
        out_next         = '0;
        if (cmd_take)
        begin
            unique case (cmd.op)
                CMD_VALUE:
                begin
                    if (!cmd.done)
                    begin
                        acc_next = merged;
                    end
                    else
                    begin
                        acc_next = 64'd0;
                        if (!expect_size_reg)
                        begin
                            held_next        = keyed;
                            wide_next        = cmd.wide;
                            expect_size_next = 1'b1;
                        end
                        else
                        begin
                            emit                     = 1'b1;
                            out_next.kind            = KIND_ENTRY;
                            out_next.entry_offset    = held_reg;
                            out_next.entry_size      = keyed;
                            out_next.has_path        = path_seen_reg;
                            out_next.value_truncated = wide_reg || cmd.wide;
                            expect_size_next         = 1'b0;
                            wide_next                = 1'b0;
                        end
                    end
                end
                CMD_STR_LEN:
                begin
                    emit                 = 1'b1;
                    out_next.kind        = KIND_PATH_START;
                    out_next.path_length = cmd.data;
                    path_seen_next       = 1'b1;
                    expect_size_next     = 1'b0;
                    wide_next            = 1'b0;
                end
                CMD_STR_BYTE:
                begin
                    emit               = 1'b1;
                    out_next.kind      = KIND_PATH_BYTE;
                    out_next.path_byte = cmd.data;
                end
                default:
                begin
                    // Skipped bytes, opcodes and nonzero LONG1 widths leave values alone.
                end
            endcase
            // End of the index returns the pairing state to reset.
            if (cmd.last)
            begin
                acc_next         = 64'd0;
                held_next        = 64'd0;
                expect_size_next = 1'b0;
                path_seen_next   = 1'b0;
                wide_next        = 1'b0;
            end
        end
    end

    // Result register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= 64'd0;
            held_reg        <= 64'd0;
            expect_size_reg <= 1'b0;
            path_seen_reg   <= 1'b0;
            wide_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            acc_reg         <= acc_next;
            held_reg        <= held_next;
            expect_size_reg <= expect_size_next;
            path_seen_reg   <= path_seen_next;
            wide_reg        <= wide_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> hdl/pickle_index_entry_parser_core.sv
// Top level of the pickle index entry parser: key register, front classifier,
// command queue and back executor. Depends on piep_pkg and the piep_ modules.
//
// Usage: index bytes enter through a queue-style port. A byte transaction
// completes on a rising edge with push high and full low. Results leave through
// a queue-style port: the oldest result is on result while empty is low and is
// taken on a rising edge with pop high. The 32-bit key is written over the
// cfg_valid/cfg_ready channel (cfg_ready is always high) while the block idles.
// Each byte is classified in the cycle it is accepted and enters a two-entry
// command queue; the back part executes one command per cycle, while its single
// result register is free or being popped. A byte that causes a result reaches
// the result port through the command queue and the result register.
// Throughput is one byte per cycle while results are popped as they appear;
// the result register sets the rate and frees in the cycle it is popped.
// When the receiver stalls, the result register holds, the back part waits,
// the command queue fills and full rises after at most two more bytes.
// Reset clears the key to zero, empties the queue and result register, and
// returns the parser to awaiting an opcode with no held offset or path.
module pickle_index_entry_parser_core
    import piep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    stream_item,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] key_reg;
    logic        accept;
    cmd_t        front_cmd;
    cmd_t        queued_cmd;
    logic        queue_nonempty;
    logic        cmd_take;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // Key register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cfg_data;
        end
    end

    piep_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (stream_item),
        .cmd    (front_cmd)
    );

    piep_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (cmd_take),
        .rd_cmd   (queued_cmd),
        .nonempty (queue_nonempty)
    );

    piep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .cmd_valid (queue_nonempty),
        .cmd       (queued_cmd),
        .cmd_take  (cmd_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

>>> tb/pickle_index_entry_parser_checker.sv
// Transaction checker for the pickle index entry parser: watches the stream, result
// and key channels, predicts each result and compares it field by field.
// Depends on piep_pkg for the payload structs, opcodes and result kinds.
module pickle_index_entry_parser_checker
    import piep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  in_item_t    stream_item,
    input  logic        empty,
    input  logic        pop,
    input  result_t     result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          matched
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser phases of the prediction.
    typedef enum logic [2:0] {
        SCAN_OPCODE,
        SCAN_BININT,
        SCAN_LONG_WIDTH,
        SCAN_LONG_BYTES,
        SCAN_STR_LEN,
        SCAN_STR_BYTES
    } scan_phase_t;

    // Shadow copy of the key register and of the parser state.
    logic [31:0] key;
    scan_phase_t phase;
    logic [7:0]  remaining;
    logic [7:0]  position;
    logic [63:0] accum;
    logic [63:0] held_offset;
    logic        want_size;
    logic        saw_path;
    logic        held_wide;

    // Results predicted but not yet popped, oldest first.
    result_t predicted_results[$];

    function automatic void clear_parser();
        phase       = SCAN_OPCODE;
        remaining   = '0;
        position    = '0;
        accum       = '0;
        held_offset = '0;
        want_size   = 1'b0;
        saw_path    = 1'b0;
        held_wide   = 1'b0;
    endfunction

    // Applies the key to a finished value; the second value of a pair closes an entry.
    function automatic bit close_value(input logic [63:0] raw, input logic wide,
                                       output result_t r);
        logic [63:0] keyed;
        keyed = raw ^ {32'd0, key};
        r     = '0;
        phase = SCAN_OPCODE;
        if (!want_size) begin
            held_offset = keyed;
            held_wide   = wide;
            want_size   = 1'b1;
            return 1'b0;
        end
        r.kind            = KIND_ENTRY;
        r.entry_offset    = held_offset;
        r.entry_size      = keyed;
        r.has_path        = saw_path;
        r.value_truncated = held_wide | wide;
        want_size = 1'b0;
        held_wide = 1'b0;
        return 1'b1;
    endfunction

    // A LONG1 value is sign extended from the highest byte that was kept.
    function automatic bit close_long1(output result_t r);
        logic [63:0] v;
        int          kept;
        kept = (position < VALUE_BYTES) ? position : VALUE_BYTES;
        v    = accum;
        if (kept > 0 && kept < 8 && v[kept * 8 - 1])
            v = v | ({64{1'b1}} << (kept * 8));
        return close_value(v, position > VALUE_BYTES, r);
    endfunction

    // Advances the parser by one stream byte; returns 1 when a result is produced.
    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        r = '0;
        case (phase)
            SCAN_BININT: begin
                accum = accum | (64'(b) << {position[1:0], 3'b000});
                position++;
                remaining--;
                if (remaining == 8'd0)
                    return close_value(accum, 1'b0, r);
                return 1'b0;
            end
            SCAN_LONG_WIDTH: begin
                accum     = '0;
                position  = '0;
                remaining = b;
                if (b == 8'd0)
                    return close_long1(r);
                phase = SCAN_LONG_BYTES;
                return 1'b0;
            end
            SCAN_LONG_BYTES: begin
                if (position < VALUE_BYTES)
                    accum = accum | (64'(b) << {position[2:0], 3'b000});
                position++;
                remaining--;
                if (remaining == 8'd0)
                    return close_long1(r);
                return 1'b0;
            end
            SCAN_STR_LEN: begin
                r.kind        = KIND_PATH_START;
                r.path_length = b;
                saw_path      = 1'b1;
                want_size     = 1'b0;
                held_wide     = 1'b0;
                remaining     = b;
                phase         = (b == 8'd0) ? SCAN_OPCODE : SCAN_STR_BYTES;
                return 1'b1;
            end
            SCAN_STR_BYTES: begin
                r.kind      = KIND_PATH_BYTE;
                r.path_byte = b;
                remaining--;
                if (remaining == 8'd0)
                    phase = SCAN_OPCODE;
                return 1'b1;
            end
            default: begin
                phase = SCAN_OPCODE;
                if (b == OP_BININT) begin
                    phase     = SCAN_BININT;
                    remaining = 8'd4;
                    position  = '0;
                    accum     = '0;
                end else if (b == OP_LONG1) begin
                    phase = SCAN_LONG_WIDTH;
                end else if (b == OP_SHORT_UNICODE) begin
                    phase = SCAN_STR_LEN;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%h, actual 0x%h", name, want, got);
            errors++;
        end
    endfunction

    // Compare popped results first, then predict from the accepted byte and track the key.
    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        result_t made;
        bit      has_result;
        if (!rst_n) begin
            key = '0;
            clear_parser();
            predicted_results.delete();
            errors  = 0;
            pending = 0;
            matched = 0;
        end else begin
            if (pop && !empty) begin
                if (predicted_results.size() == 0) begin
                    $error("result transaction with none predicted: kind %0d", result.kind);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(result.kind));
                    check_field("path_length", 64'(want.path_length), 64'(result.path_length));
                    check_field("path_byte", 64'(want.path_byte), 64'(result.path_byte));
                    check_field("entry_offset", want.entry_offset, result.entry_offset);
                    check_field("entry_size", want.entry_size, result.entry_size);
                    check_field("has_path", 64'(want.has_path), 64'(result.has_path));
                    check_field("value_truncated", 64'(want.value_truncated),
                                64'(result.value_truncated));
                    matched++;
                end
            end
            if (push && !full) begin
                has_result = parse_byte(stream_item.data_byte, made);
                if (stream_item.last_of_index)
                    clear_parser();
                if (has_result)
                    predicted_results.push_back(made);
            end
            if (cfg_valid && cfg_ready)
                key = cfg_data;
            pending = predicted_results.size();
        end
    end

endmodule

>>> tb/pickle_index_entry_parser_core_tb.sv
// Top of the pickle index entry parser testbench: clock, reset, stream and key
// stimulus, random result stalls and the verdict. Depends on piep_pkg, the core
// and pickle_index_entry_parser_checker.
module pickle_index_entry_parser_core_tb;
    import piep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_RECORDS = 170;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    stream_item;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int errors;
    int pending;
    int matched;
    int bytes_sent;
    int parsed_bytes;
    int keys_written;
    int cycles;
    int stall_left;
    bit no_gaps;

    pickle_index_entry_parser_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .stream_item (stream_item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    pickle_index_entry_parser_checker i_entry_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .stream_item (stream_item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .matched     (matched)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_length();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 45)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Payload byte with extra weight on the all-zero and all-one values.
    function automatic logic [7:0] payload_byte();
        int p;
        p = $urandom_range(0, 99);
        if (p < 15)
            return 8'h00;
        if (p < 30)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Offers one byte after a random gap and returns at the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        stream_item <= '{data_byte: b, last_of_index: lst};
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    // Stops the stream and waits until every predicted result has been popped.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [31:0] k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        keys_written++;
    endtask

    // Sends an opcode with its operand bytes; the index may end on the last one.
    task automatic send_opcode(input logic [7:0] op, input logic [7:0] operand[$],
                               input logic end_index);
        send_byte(op, end_index && operand.size() == 0);
        foreach (operand[i])
            send_byte(operand[i], end_index && i == operand.size() - 1);
        parsed_bytes += 1 + operand.size();
    endtask

    // One random record: mostly well-formed opcodes, some noise and cut-off opcodes.
    task automatic send_record();
        logic [7:0] operand[$];
        logic [7:0] op;
        int         pick;
        int         n;
        int         p;
        if ($urandom_range(0, 19) == 0)
            no_gaps = !no_gaps;
        pick = $urandom_range(0, 99);
        p    = $urandom_range(0, 99);
        if (pick < 28) begin
            op = OP_SHORT_UNICODE;
            n  = (p < 55) ? $urandom_range(0, 4) : (p < 90) ? $urandom_range(5, 24) :
                 (p < 98) ? $urandom_range(25, 80) : 255;
            operand.push_back(8'(n));
            repeat (n) operand.push_back(payload_byte());
        end else if (pick < 52) begin
            op = OP_BININT;
            repeat (4) operand.push_back(payload_byte());
        end else if (pick < 78) begin
            op = OP_LONG1;
            n  = (p < 10) ? 0 : (p < 70) ? $urandom_range(1, 8) :
                 (p < 95) ? $urandom_range(9, 16) : (p < 99) ? $urandom_range(17, 40) : 255;
            operand.push_back(8'(n));
            repeat (n) operand.push_back(payload_byte());
        end else if (pick < 88) begin
            // Noise byte between opcodes; it is not counted as parsed input.
            send_byte(8'($urandom), $urandom_range(0, 29) == 0);
            return;
        end else begin
            // Opcode cut short by the end of the index.
            case ($urandom_range(0, 2))
                0:       op = OP_BININT;
                1:       op = OP_LONG1;
                default: op = OP_SHORT_UNICODE;
            endcase
            if (op == OP_BININT)
                repeat ($urandom_range(0, 3)) operand.push_back(payload_byte());
            else
                operand.push_back(8'($urandom_range(2, 40)));
            send_opcode(op, operand, 1'b1);
            return;
        end
        send_opcode(op, operand, $urandom_range(0, 24) == 0);
    endtask

    // Result side: pop with random stalls.
    initial begin
        pop        = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = idle_length();
            end
        end
    end

    // Stream side and verdict.
    initial begin
        logic [31:0] keys[5];
        logic [7:0]  opening[$];
        push         = 1'b0;
        stream_item  = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        bytes_sent   = 0;
        parsed_bytes = 0;
        keys_written = 0;
        no_gaps      = 1'b0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening with the reset key: skipped byte, empty path, maximum
        // BININT, zero-width LONG1, a path, a LONG1 wider than the kept bytes with a
        // negative kept top byte, a one-byte negative LONG1, and an index ending
        // inside a BININT.
        opening = '{8'h00, OP_SHORT_UNICODE, 8'h00,
                    OP_BININT, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    OP_LONG1, 8'h00,
                    OP_SHORT_UNICODE, 8'h01, 8'hFF,
                    OP_LONG1, 8'h09, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                    8'h88, 8'h55,
                    OP_LONG1, 8'h01, 8'h80,
                    OP_BININT, 8'h00};
        foreach (opening[i])
            send_byte(opening[i], i == opening.size() - 1);

        // Random records under several keys, the extremes among them.
        keys = '{32'hFFFF_FFFF, 32'h0000_0000, 32'($urandom), 32'h8000_0000, 32'($urandom)};
        foreach (keys[k]) begin
            wait_idle();
            write_key(keys[k]);
            while (parsed_bytes < (k + 1) * PHASE_RECORDS)
                send_record();
        end
        wait_idle();

        $display("Sent %0d stream bytes, %0d of them in opcodes, under %0d written keys.",
                 bytes_sent, parsed_bytes, keys_written);
        $display("Compared %0d result transactions; %0d mismatches.", matched, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
